@@ src/ivpr_pkg.sv @@
package ivpr_pkg;

  localparam int POOL_BASE = 64;
  localparam int POOL_SIZE = 64;

  localparam int VEC_W = 8;
  localparam int HND_W = 64;
  localparam int CAP_W = 32;
  localparam int CNT_W = 7;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;
  localparam int ACT_W = 2;

  localparam int SLOT_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int GRP_N  = (POOL_SIZE + 7) / 8;
  localparam int GRP_W  = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int PAD_N  = GRP_N * 8;

  localparam logic [VEC_W-1:0] EOI_PRI_MIN = 8'h20;
  localparam logic [VEC_W-1:0] EOI_SEC_MIN = 8'd40;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REG   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNREG = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DISP  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_POOL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_ROUTE_INV = 3'd4;
  localparam logic [STAT_W-1:0] ST_DENIED    = 3'd5;

  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UNMASK = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MASK   = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_INVALID_CAP = 1'b0;
  localparam logic [CAP_W-1:0] INVALID_CAP_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic capture;
    logic commit;
  } ivpr_cmd_t;

  function automatic logic pool_hit(input logic [VEC_W-1:0] vec);
    logic [VEC_W:0] ext;
    logic [VEC_W:0] ofs;
    ext = {1'b0, vec};
    ofs = ext - (VEC_W+1)'(POOL_BASE);
    return (ext >= (VEC_W+1)'(POOL_BASE)) && (ofs < (VEC_W+1)'(POOL_SIZE));
  endfunction

  function automatic logic [SLOT_W-1:0] pool_slot(input logic [VEC_W-1:0] vec);
    logic [VEC_W-1:0] ofs;
    ofs = vec - VEC_W'(POOL_BASE);
    return SLOT_W'(ofs);
  endfunction

  // lowest clear bit of a byte
  function automatic logic [2:0] first_zero8(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

@@ src/ivpr_ifs.sv @@
interface ivpr_req_if import ivpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [VEC_W-1:0]  vector;
  logic [HND_W-1:0]  handler_addr;
  logic [CAP_W-1:0]  cap_handle;
  logic              level_trigger;
  logic              rights_ok;

  modport source (output valid, kind, vector, handler_addr, cap_handle, level_trigger,
                  rights_ok, input ready);
  modport sink (input valid, kind, vector, handler_addr, cap_handle, level_trigger,
                rights_ok, output ready);
endinterface

interface ivpr_rsp_if import ivpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VEC_W-1:0]  vector_out;
  logic              deliver;
  logic [HND_W-1:0]  handler_out;
  logic              eoi_primary;
  logic              eoi_secondary;
  logic [ACT_W-1:0]  hw_action;
  logic              line_level;
  logic [CNT_W-1:0]  alloc_count;
  logic [CNT_W-1:0]  peak_allocated;

  modport source (output valid, status, vector_out, deliver, handler_out, eoi_primary,
                  eoi_secondary, hw_action, line_level, alloc_count, peak_allocated,
                  input ready);
  modport sink (input valid, status, vector_out, deliver, handler_out, eoi_primary,
                eoi_secondary, hw_action, line_level, alloc_count, peak_allocated,
                output ready);
endinterface

@@ src/ivpr_ctrl.sv @@
module ivpr_ctrl import ivpr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output ivpr_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // result register must be free or draining this cycle
  assign cmd.commit  = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ src/ivpr_dpath.sv @@
module ivpr_dpath import ivpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ivpr_cmd_t         cmd,
  input  logic [KIND_W-1:0] kind,
  input  logic [VEC_W-1:0]  vector,
  input  logic [HND_W-1:0]  handler_addr,
  input  logic [CAP_W-1:0]  cap_handle,
  input  logic              level_trigger,
  input  logic              rights_ok,
  input  logic [CAP_W-1:0]  invalid_cap_code,
  output logic [STAT_W-1:0] status,
  output logic [VEC_W-1:0]  vector_out,
  output logic              deliver,
  output logic [HND_W-1:0]  handler_out,
  output logic              eoi_primary,
  output logic              eoi_secondary,
  output logic [ACT_W-1:0]  hw_action,
  output logic              line_level,
  output logic [CNT_W-1:0]  alloc_count,
  output logic [CNT_W-1:0]  peak_allocated
);

  // latched item
  logic [KIND_W-1:0] op_kind;
  logic [VEC_W-1:0]  op_vec;
  logic [HND_W-1:0]  op_hnd;
  logic [CAP_W-1:0]  op_cap;
  logic              op_lvl;
  logic              op_rights;

  // pool state
  logic [POOL_SIZE-1:0] slot_used;
  logic [POOL_SIZE-1:0] route_valid;
  logic [CNT_W-1:0]     used_count, used_count_next;
  logic [CNT_W-1:0]     peak_count, peak_count_next;

  // route table: handler and capability
  logic [HND_W+CAP_W-1:0] route_mem [POOL_SIZE];
  logic [HND_W+CAP_W-1:0] rd_data;

  // first-fit search, group stage registered at capture
  logic [PAD_N-1:0] used_pad;
  logic [GRP_N-1:0] grp_free;
  logic [2:0]       grp_first [GRP_N];

  logic             alloc_found;
  logic [GRP_W-1:0] alloc_grp;
  logic [SLOT_W-1:0] alloc_slot;

  logic              ex_hit;
  logic [SLOT_W-1:0] ex_slot;
  logic              ex_used;
  logic              ex_rv;
  logic [HND_W-1:0]  rd_hnd;
  logic [CAP_W-1:0]  rd_cap;

  logic [STAT_W-1:0] st_c;
  logic [VEC_W-1:0]  vout_c;
  logic              dlv_c;
  logic [HND_W-1:0]  hout_c;
  logic              eoi1_c, eoi2_c;
  logic [ACT_W-1:0]  act_c;
  logic              lvl_c;
  logic              set_used, clr_used, set_valid, clr_valid, mem_we;
  logic [SLOT_W-1:0] upd_slot;

  always_comb begin
    used_pad = '1;
    used_pad[POOL_SIZE-1:0] = slot_used;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind   <= kind;
      op_vec    <= vector;
      op_hnd    <= handler_addr;
      op_cap    <= cap_handle;
      op_lvl    <= level_trigger;
      op_rights <= rights_ok;
      for (int g = 0; g < GRP_N; g++) begin
        grp_free[g]  <= ~&used_pad[g*8 +: 8];
        grp_first[g] <= first_zero8(used_pad[g*8 +: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && pool_hit(vector)) rd_data <= route_mem[pool_slot(vector)];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) route_mem[ex_slot] <= {op_hnd, op_cap};
  end

  always_comb begin
    alloc_found = 1'b0;
    alloc_grp   = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        alloc_found = 1'b1;
        alloc_grp   = GRP_W'(g);
      end
    end
  end

  assign alloc_slot = SLOT_W'({alloc_grp, grp_first[alloc_grp]});

  assign ex_hit  = pool_hit(op_vec);
  assign ex_slot = pool_slot(op_vec);
  assign ex_used = ex_hit && slot_used[ex_slot];
  assign ex_rv   = ex_hit && route_valid[ex_slot];
  assign rd_hnd  = rd_data[HND_W+CAP_W-1:CAP_W];
  assign rd_cap  = rd_data[CAP_W-1:0];

  always_comb begin
    st_c            = ST_OK;
    vout_c          = op_vec;
    dlv_c           = 1'b0;
    hout_c          = '0;
    eoi1_c          = 1'b0;
    eoi2_c          = 1'b0;
    act_c           = ACT_NONE;
    lvl_c           = 1'b0;
    set_used        = 1'b0;
    clr_used        = 1'b0;
    set_valid       = 1'b0;
    clr_valid       = 1'b0;
    mem_we          = 1'b0;
    upd_slot        = ex_slot;
    used_count_next = used_count;
    peak_count_next = peak_count;
    case (op_kind)
      KIND_ALLOC: begin
        if (alloc_found) begin
          set_used        = 1'b1;
          upd_slot        = alloc_slot;
          used_count_next = used_count + CNT_W'(1);
          if (used_count_next > peak_count) peak_count_next = used_count_next;
          vout_c = VEC_W'(POOL_BASE) + VEC_W'(alloc_slot);
        end else begin
          st_c   = ST_FULL;
          vout_c = '0;
        end
      end
      KIND_FREE: begin
        if (!ex_hit) begin
          st_c = ST_NOT_POOL;
        end else begin
          if (ex_used) begin
            clr_used        = 1'b1;
            used_count_next = used_count - CNT_W'(1);
          end else begin
            st_c = ST_NOT_ALLOC;
          end
          clr_valid = 1'b1;
          act_c     = ACT_MASK;
        end
      end
      KIND_REG: begin
        if (!ex_hit) begin
          st_c = ST_NOT_POOL;
        end else if (!ex_used) begin
          st_c = ST_NOT_ALLOC;
        end else begin
          mem_we    = 1'b1;
          set_valid = 1'b1;
          act_c     = ACT_UNMASK;
          lvl_c     = op_lvl;
        end
      end
      KIND_UNREG: begin
        if (!ex_hit) begin
          st_c = ST_NOT_POOL;
        end else begin
          clr_valid = 1'b1;
          act_c     = ACT_MASK;
        end
      end
      KIND_DISP: begin
        if (!ex_rv || rd_hnd == '0) begin
          st_c = ST_ROUTE_INV;
        end else if (rd_cap != invalid_cap_code && !op_rights) begin
          st_c = ST_DENIED;
        end else begin
          dlv_c  = 1'b1;
          hout_c = rd_hnd;
          eoi1_c = (op_vec >= EOI_PRI_MIN);
          eoi2_c = (op_vec >= EOI_PRI_MIN) && (op_vec >= EOI_SEC_MIN);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used   <= '0;
      route_valid <= '0;
      used_count  <= '0;
      peak_count  <= '0;
    end else if (cmd.commit) begin
      if (set_used)  slot_used[upd_slot]  <= 1'b1;
      if (clr_used)  slot_used[upd_slot]  <= 1'b0;
      if (set_valid) route_valid[upd_slot] <= 1'b1;
      if (clr_valid) route_valid[upd_slot] <= 1'b0;
      used_count <= used_count_next;
      peak_count <= peak_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= st_c;
      vector_out      <= vout_c;
      deliver         <= dlv_c;
      handler_out     <= hout_c;
      eoi_primary     <= eoi1_c;
      eoi_secondary   <= eoi2_c;
      hw_action       <= act_c;
      line_level      <= lvl_c;
      alloc_count     <= used_count_next;
      peak_allocated  <= peak_count_next;
    end
  end

endmodule

@@ src/irq_vector_pool_router.sv @@
// A result beat is offered when the accepted item commits, which waits while an
// earlier beat is stalled. One item is in flight at a time. The route table read
// happens in the accept cycle, the bitmap/route update and result load at commit.
// The first-fit search is split into a byte-group stage (registered at accept) and a
// group pick. Reset (rst, synchronous) clears the slot bitmap, route valid flags and
// counters at once and sets invalid_cap_code to all ones; no clearing pass.
module irq_vector_pool_router import ivpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ivpr_req_if.sink              req,
  ivpr_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  ivpr_cmd_t        cmd;
  logic [CAP_W-1:0] invalid_cap_code;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_INVALID_CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_cap_code <= INVALID_CAP_RESET;
    end else if (cfg_wr) begin
      invalid_cap_code <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_INVALID_CAP) ? invalid_cap_code : '0;

  ivpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd)
  );

  ivpr_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .kind             (req.kind),
    .vector           (req.vector),
    .handler_addr     (req.handler_addr),
    .cap_handle       (req.cap_handle),
    .level_trigger    (req.level_trigger),
    .rights_ok        (req.rights_ok),
    .invalid_cap_code (invalid_cap_code),
    .status           (rsp.status),
    .vector_out       (rsp.vector_out),
    .deliver          (rsp.deliver),
    .handler_out      (rsp.handler_out),
    .eoi_primary      (rsp.eoi_primary),
    .eoi_secondary    (rsp.eoi_secondary),
    .hw_action        (rsp.hw_action),
    .line_level       (rsp.line_level),
    .alloc_count      (rsp.alloc_count),
    .peak_allocated   (rsp.peak_allocated)
  );

endmodule

@@ src/ivpr_chk.sv @@
module ivpr_chk import ivpr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STAT_W-1:0] rsp_status,
  input logic              rsp_deliver,
  input logic [HND_W-1:0]  rsp_handler_out,
  input logic [ACT_W-1:0]  rsp_hw_action,
  input logic [CNT_W-1:0]  rsp_alloc_count,
  input logic [CNT_W-1:0]  rsp_peak_allocated
);

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while one is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("stalled result beat changed or dropped");

  a_deliver_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_deliver |-> rsp_status == ST_OK && rsp_hw_action == ACT_NONE)
    else $error("delivery with bad status or line action");

  a_handler_gated: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_deliver |-> rsp_handler_out == '0)
    else $error("handler shown without delivery");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_alloc_count <= rsp_peak_allocated)
    else $error("allocated count above watermark");

endmodule

bind irq_vector_pool_router ivpr_chk u_ivpr_chk (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_deliver         (rsp.deliver),
  .rsp_handler_out     (rsp.handler_out),
  .rsp_hw_action       (rsp.hw_action),
  .rsp_alloc_count     (rsp.alloc_count),
  .rsp_peak_allocated  (rsp.peak_allocated)
);

@@ dv/tb_irq_vector_pool_router.sv @@
`timescale 1ns / 1ps

module tb_irq_vector_pool_router;
  import ivpr_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 120;
  localparam int N_PHASES     = 4;
  localparam int SETTLE       = 4;
  localparam int TAIL         = 10;

  // kinds the block ignores
  localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_C = 3'd7;

  localparam logic [CFG_ADDR_W-1:0] ADDR_INVALID_CAP =
    CFG_ADDR_W'({CFG_IDX_INVALID_CAP, 2'b00});

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VEC_W-1:0]  vector;
    logic [HND_W-1:0]  handler;
    logic [CAP_W-1:0]  cap;
    logic              level;
    logic              rights;
  } vec_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VEC_W-1:0]  vector_out;
    logic              deliver;
    logic [HND_W-1:0]  handler_out;
    logic              eoi_primary;
    logic              eoi_secondary;
    logic [ACT_W-1:0]  hw_action;
    logic              line_level;
    logic [CNT_W-1:0]  alloc_cnt;
    logic [CNT_W-1:0]  peak_cnt;
  } vec_rsp_t;

  class vector_pool_shadow;
    logic              used [POOL_SIZE];
    logic              routed [POOL_SIZE];
    logic [HND_W-1:0]  handler [POOL_SIZE];
    logic [CAP_W-1:0]  cap [POOL_SIZE];
    logic              level [POOL_SIZE];
    logic [CNT_W-1:0]  used_cnt;
    logic [CNT_W-1:0]  peak_cnt;
    logic [CAP_W-1:0]  no_check_cap;
    vec_rsp_t          expected_rsp [$];
    int                n_err;

    function new();
      for (int i = 0; i < POOL_SIZE; i++) begin
        used[i] = 1'b0;
        routed[i] = 1'b0;
        handler[i] = '0;
        cap[i] = '0;
        level[i] = 1'b0;
      end
      used_cnt = '0;
      peak_cnt = '0;
      no_check_cap = INVALID_CAP_RESET;
      n_err = 0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // a live slot, or one with a route when asked; low slots if none
    function logic [VEC_W-1:0] live_vector(bit want_route);
      int cand [$];
      for (int i = 0; i < POOL_SIZE; i++)
        if (used[i] && (!want_route || routed[i])) cand.push_back(i);
      if (cand.size() == 0) return VEC_W'(POOL_BASE + $urandom_range(0, 3));
      return VEC_W'(POOL_BASE + cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    function void note_request(vec_req_t it);
      vec_rsp_t r;
      bit       hit;
      int       s;
      r = '0;
      r.status = ST_OK;
      r.vector_out = it.vector;
      r.hw_action = ACT_NONE;
      hit = (int'(it.vector) >= POOL_BASE) && (int'(it.vector) < POOL_BASE + POOL_SIZE);
      s = int'(it.vector) - POOL_BASE;
      case (it.kind)
        KIND_ALLOC: begin
          r.status = ST_FULL;
          r.vector_out = '0;
          for (int i = 0; i < POOL_SIZE; i++) begin
            if (!used[i]) begin
              used[i] = 1'b1;
              used_cnt = used_cnt + 1'b1;
              if (used_cnt > peak_cnt) peak_cnt = used_cnt;
              r.status = ST_OK;
              r.vector_out = VEC_W'(POOL_BASE + i);
              break;
            end
          end
        end
        KIND_FREE: begin
          if (!hit) r.status = ST_NOT_POOL;
          else begin
            if (used[s]) begin
              used[s] = 1'b0;
              used_cnt = used_cnt - 1'b1;
            end else begin
              r.status = ST_NOT_ALLOC;
            end
            routed[s] = 1'b0;
            handler[s] = '0;
            cap[s] = no_check_cap;
            r.hw_action = ACT_MASK;
          end
        end
        KIND_REG: begin
          if (!hit) r.status = ST_NOT_POOL;
          else if (!used[s]) r.status = ST_NOT_ALLOC;
          else begin
            handler[s] = it.handler;
            cap[s] = it.cap;
            level[s] = it.level;
            routed[s] = 1'b1;
            r.hw_action = ACT_UNMASK;
            r.line_level = it.level;
          end
        end
        KIND_UNREG: begin
          if (!hit) r.status = ST_NOT_POOL;
          else begin
            routed[s] = 1'b0;
            handler[s] = '0;
            r.hw_action = ACT_MASK;
          end
        end
        KIND_DISP: begin
          if (!hit || !routed[s] || handler[s] == '0) r.status = ST_ROUTE_INV;
          else if (cap[s] != no_check_cap && !it.rights) r.status = ST_DENIED;
          else begin
            r.deliver = 1'b1;
            r.handler_out = handler[s];
            r.eoi_primary = (it.vector >= EOI_PRI_MIN);
            r.eoi_secondary = (it.vector >= EOI_PRI_MIN) && (it.vector >= EOI_SEC_MIN);
          end
        end
        default: ;
      endcase
      r.alloc_cnt = used_cnt;
      r.peak_cnt = peak_cnt;
      expected_rsp.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      n_err++;
    endtask

    task chk_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_response(vec_rsp_t got);
      vec_rsp_t w;
      if (expected_rsp.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      w = expected_rsp.pop_front();
      chk_field("status", 64'(got.status), 64'(w.status));
      chk_field("vector_out", 64'(got.vector_out), 64'(w.vector_out));
      chk_field("deliver", 64'(got.deliver), 64'(w.deliver));
      chk_field("handler_out", got.handler_out, w.handler_out);
      chk_field("eoi_primary", 64'(got.eoi_primary), 64'(w.eoi_primary));
      chk_field("eoi_secondary", 64'(got.eoi_secondary), 64'(w.eoi_secondary));
      chk_field("hw_action", 64'(got.hw_action), 64'(w.hw_action));
      chk_field("line_level", 64'(got.line_level), 64'(w.line_level));
      chk_field("alloc_count", 64'(got.alloc_cnt), 64'(w.alloc_cnt));
      chk_field("peak_allocated", 64'(got.peak_cnt), 64'(w.peak_cnt));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ivpr_req_if req_bus ();
  ivpr_rsp_if rsp_bus ();

  irq_vector_pool_router dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vector_pool_shadow shadow = new();
  int  n_sent = 0;
  bit  calm = 1'b0;
  int  idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin : rsp_sink
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        rsp_bus.ready <= 1'b0;
      end else if (!held && n_sent >= 150) begin
        held = 1'b1;
        stall = HOLD_CYCLES - 1;
        rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 11);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    vec_rsp_t got;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.status = rsp_bus.status;
      got.vector_out = rsp_bus.vector_out;
      got.deliver = rsp_bus.deliver;
      got.handler_out = rsp_bus.handler_out;
      got.eoi_primary = rsp_bus.eoi_primary;
      got.eoi_secondary = rsp_bus.eoi_secondary;
      got.hw_action = rsp_bus.hw_action;
      got.line_level = rsp_bus.line_level;
      got.alloc_cnt = rsp_bus.alloc_count;
      got.peak_cnt = rsp_bus.peak_allocated;
      shadow.check_response(got);
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_irq_vector_pool_router: done, errors");
      $finish;
    end
  end

  function automatic vec_req_t mk(logic [KIND_W-1:0] kind, logic [VEC_W-1:0] vec,
                                  logic [HND_W-1:0] h, logic [CAP_W-1:0] c,
                                  logic lvl, logic rights);
    vec_req_t it;
    it.kind = kind;
    it.vector = vec;
    it.handler = h;
    it.cap = c;
    it.level = lvl;
    it.rights = rights;
    return it;
  endfunction

  task automatic send_beat(input vec_req_t it);
    @(negedge clk);
    req_bus.valid <= 1'b1;
    req_bus.kind <= it.kind;
    req_bus.vector <= it.vector;
    req_bus.handler_addr <= it.handler;
    req_bus.cap_handle <= it.cap;
    req_bus.level_trigger <= it.level;
    req_bus.rights_ok <= it.rights;
    do @(posedge clk); while (!req_bus.ready);
    shadow.note_request(it);
    n_sent++;
  endtask

  task automatic sender_gap();
    int n;
    if (calm || $urandom_range(0, 5) != 0) return;
    n = $urandom_range(1, 12);
    @(negedge clk);
    req_bus.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop offering and let every outstanding beat come back
  task automatic drain();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_no_check_cap(input logic [CAP_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_INVALID_CAP;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.no_check_cap = v;
    // read back
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) shadow.report($sformatf("invalid_cap_code readback %0h want %0h",
                                              prdata, v));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic vec_req_t random_request(int phase);
    vec_req_t it;
    int       k;
    int       pv;
    int       a_alloc;
    int       a_free;
    int       a_reg;
    int       a_unreg;
    // phase 0 fills the pool, phase 1 drains it, the rest mix
    case (phase)
      0:       begin a_alloc = 62; a_free = 67; a_reg = 82; a_unreg = 86; end
      1:       begin a_alloc = 15; a_free = 45; a_reg = 65; a_unreg = 72; end
      default: begin a_alloc = 30; a_free = 45; a_reg = 68; a_unreg = 75; end
    endcase
    k = $urandom_range(0, 99);
    if (k < a_alloc) it.kind = KIND_ALLOC;
    else if (k < a_free) it.kind = KIND_FREE;
    else if (k < a_reg) it.kind = KIND_REG;
    else if (k < a_unreg) it.kind = KIND_UNREG;
    else if (k < 97) it.kind = KIND_DISP;
    else it.kind = KIND_W'($urandom_range(KIND_RSVD_A, KIND_RSVD_C));

    pv = $urandom_range(0, 99);
    if (pv < 65) it.vector = shadow.live_vector(it.kind == KIND_DISP && pv < 50);
    else if (pv < 85) it.vector = VEC_W'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1));
    else it.vector = VEC_W'($urandom_range(0, 255));

    k = $urandom_range(0, 9);
    if (k == 0) it.handler = '0;
    else if (k == 1) it.handler = '1;
    else it.handler = {$urandom, $urandom};

    k = $urandom_range(0, 19);
    if (k < 7) it.cap = shadow.no_check_cap;
    else if (k < 10) it.cap = '0;
    else if (k < 13) it.cap = '1;
    else it.cap = $urandom;

    it.level = 1'($urandom_range(0, 1));
    it.rights = 1'($urandom_range(0, 1));
    return it;
  endfunction

  initial begin : stimulus
    vec_req_t    dir [$];
    logic [CAP_W-1:0] cap_plan [N_PHASES];

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_bus.valid = 1'b0;
    req_bus.kind = '0;
    req_bus.vector = '0;
    req_bus.handler_addr = '0;
    req_bus.cap_handle = '0;
    req_bus.level_trigger = 1'b0;
    req_bus.rights_ok = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dir.push_back(mk(KIND_DISP, 8'd0, '1, '1, 1'b0, 1'b1));
    dir.push_back(mk(KIND_FREE, VEC_W'(POOL_BASE - 1), '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_REG, VEC_W'(POOL_BASE + POOL_SIZE), '1, '0, 1'b1, 1'b0));
    dir.push_back(mk(KIND_UNREG, 8'hFF, '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_FREE, VEC_W'(POOL_BASE), '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_REG, VEC_W'(POOL_BASE), 64'h1, '1, 1'b1, 1'b0));
    dir.push_back(mk(KIND_UNREG, VEC_W'(POOL_BASE + POOL_SIZE - 1), '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_DISP, VEC_W'(POOL_BASE), '0, '0, 1'b0, 1'b1));
    dir.push_back(mk(KIND_ALLOC, '0, '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_ALLOC, '1, '1, '1, 1'b1, 1'b1));
    // zero handler never delivers
    dir.push_back(mk(KIND_REG, VEC_W'(POOL_BASE), '0, '1, 1'b1, 1'b0));
    dir.push_back(mk(KIND_DISP, VEC_W'(POOL_BASE), '0, '0, 1'b0, 1'b1));
    // overwrite existing route
    dir.push_back(mk(KIND_REG, VEC_W'(POOL_BASE), '1, '1, 1'b0, 1'b0));
    dir.push_back(mk(KIND_DISP, VEC_W'(POOL_BASE), '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_REG, VEC_W'(POOL_BASE + 1), 64'h8000_0000_0000_0001, '0, 1'b1,
                     1'b0));
    dir.push_back(mk(KIND_DISP, VEC_W'(POOL_BASE + 1), '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_DISP, VEC_W'(POOL_BASE + 1), '0, '0, 1'b0, 1'b1));
    dir.push_back(mk(KIND_UNREG, VEC_W'(POOL_BASE + 1), '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_DISP, VEC_W'(POOL_BASE + 1), '0, '0, 1'b0, 1'b1));
    dir.push_back(mk(KIND_RSVD_A, 8'hFF, '1, '1, 1'b1, 1'b1));
    dir.push_back(mk(KIND_RSVD_B, 8'h00, '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_RSVD_C, 8'hA5, '1, '0, 1'b1, 1'b0));
    dir.push_back(mk(KIND_FREE, VEC_W'(POOL_BASE), '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_FREE, VEC_W'(POOL_BASE + 1), '0, '0, 1'b0, 1'b0));
    dir.push_back(mk(KIND_ALLOC, '0, '0, '0, 1'b0, 1'b0));

    foreach (dir[i]) begin
      sender_gap();
      send_beat(dir[i]);
    end
    drain();

    cap_plan[0] = INVALID_CAP_RESET;
    cap_plan[1] = '0;
    cap_plan[2] = $urandom;
    cap_plan[3] = '1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) write_no_check_cap(cap_plan[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == N_PHASES - 1 && n == PHASE_ITEMS / 2) calm = 1'b1;
        sender_gap();
        send_beat(random_request(ph));
      end
      drain();
    end

    repeat (TAIL) @(posedge clk);
    if (shadow.n_err == 0 && shadow.pending() == 0)
      $display("tb_irq_vector_pool_router: done, clean");
    else
      $display("tb_irq_vector_pool_router: done, errors");
    $finish;
  end

endmodule
